@@ hdl/vpp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pkg
// Shared types, register codes and helpers for the pixel packer.
// ----------------------------------------------------------------------------
package vpp_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned WORD_W    = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_FLD    = 3'd0,
        CFG_GREEN_FLD  = 3'd1,
        CFG_BLUE_FLD   = 3'd2,
        CFG_FORMAT     = 3'd3,
        CFG_MSB_FIRST  = 3'd4,
        CFG_GRAY       = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FMT_32 = 2'd0,
        FMT_24 = 2'd1,
        FMT_16 = 2'd2,
        FMT_8  = 2'd3
    } t_fmt;

    localparam logic [WORD_W-1:0] RED_FLD_RST   = 32'h00ff_0000;
    localparam logic [WORD_W-1:0] GREEN_FLD_RST = 32'h0000_ff00;
    localparam logic [WORD_W-1:0] BLUE_FLD_RST  = 32'h0000_00ff;

    typedef struct packed {
        logic [WORD_W-1:0] red_fld;
        logic [WORD_W-1:0] green_fld;
        logic [WORD_W-1:0] blue_fld;
        logic [4:0]        red_top;
        logic [4:0]        green_top;
        logic [4:0]        blue_top;
        t_fmt              fmt;
        logic              msb_first;
        logic              gray;
    } t_cfg;

    typedef struct packed {
        logic fire;    // request moves into the output register
        logic row;     // first pixel of a row
        logic active;  // 8 bpp dither mode
    } t_dith_ctl;

    // Position of the highest set bit; an empty mask gives 0 (its field is
    // masked to nothing anyway).
    function automatic logic [4:0] top_bit(input logic [WORD_W-1:0] mask);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (mask[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ hdl/vpp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_if
// Valid/ready channels of the pixel packer: pixels in, words out, config.
// ----------------------------------------------------------------------------
interface vpp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       row_begin;

    modport source (output valid, red_in, green_in, blue_in, row_begin, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, row_begin, output ready);
endinterface

interface vpp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;

    modport source (output valid, pixel_word, input ready);
    modport sink   (input valid, pixel_word, output ready);
endinterface

interface vpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/vpp_pack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_pack
// Packs one pixel into a 32, 24 or 16 bpp word, colour or gray.
// ----------------------------------------------------------------------------
module vpp_pack (
    input  vpp_pkg::t_cfg i_cfg,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    output logic [31:0]   o_word
);

    function automatic logic [31:0] place(input logic [7:0] v, input logic [4:0] top,
                                          input logic [31:0] mask);
        logic [39:0] wide;
        wide = (40'(v) << top) >> 7;
        return wide[31:0] & mask;
    endfunction

    logic [31:0] u;
    logic [7:0]  g;

    assign u = place(i_red,   i_cfg.red_top,   i_cfg.red_fld)
             | place(i_green, i_cfg.green_top, i_cfg.green_fld)
             | place(i_blue,  i_cfg.blue_top,  i_cfg.blue_fld);
    assign g = i_red;

    always_comb begin
        o_word = '0;
        if (i_cfg.gray) begin
            unique case (i_cfg.fmt)
                vpp_pkg::FMT_32: o_word = i_cfg.msb_first ? {g, g, g, 8'h00}
                                                          : {8'h00, g, g, g};
                vpp_pkg::FMT_24: o_word = {8'h00, g, g, g};
                default:         o_word = {16'h0000, g[7:3], g[7:2], g[7:3]};
            endcase
        end else begin
            unique case (i_cfg.fmt)
                vpp_pkg::FMT_32: o_word = i_cfg.msb_first ? {u[7:0], u[15:8], u[23:16], u[31:24]}
                                                          : u;
                vpp_pkg::FMT_24: o_word = i_cfg.msb_first ? {8'h00, u[7:0], u[15:8], u[23:16]}
                                                          : {8'h00, u[23:0]};
                default:         o_word = i_cfg.msb_first ? {16'h0000, u[7:0], u[15:8]}
                                                          : {16'h0000, u[15:0]};
            endcase
        end
    end

endmodule

@@ hdl/vpp_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpp_dither
// Row-wise error-diffusion dither to a 5x5x5 palette index, with the three
// wrapping 8-bit error registers.
// ----------------------------------------------------------------------------
module vpp_dither (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vpp_pkg::t_dith_ctl  i_ctl,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    output logic [6:0]          o_index
);

    // Returns {level, new error}.
    function automatic logic [10:0] quant(input logic [7:0] t, input logic [7:0] d);
        logic signed [9:0] ds;
        logic signed [9:0] ts;
        logic signed [9:0] s;
        logic signed [9:0] q;
        logic signed [9:0] e;
        ds = signed'({{2{d[7]}}, d});
        ts = signed'({2'b00, t});
        s  = ts + ds;
        if (s > 10'sd0 && s < 10'sd256) begin
            if (ds > -10'sd32 && ds < 10'sd32) begin
                q = (s + 10'sd31) & 10'sh1c0;
            end else if (ds > 10'sd31) begin
                q = (ts + 10'sd63) & 10'sh1c0;
            end else begin
                q = ts & 10'sh1c0;
            end
        end else if (s > 10'sd255) begin
            q = 10'sh100;
        end else begin
            q = 10'sd0;
        end
        e = s - q;
        return {q[8:6], e[7:0]};
    endfunction

    logic [7:0]  r_red_err, r_green_err, r_blue_err;
    logic [7:0]  n_red_err, n_green_err, n_blue_err;
    logic [7:0]  d_red, d_green, d_blue;
    logic [10:0] q_red, q_green, q_blue;

    // row start clears the error before the pixel is used
    assign d_red   = i_ctl.row ? 8'h00 : r_red_err;
    assign d_green = i_ctl.row ? 8'h00 : r_green_err;
    assign d_blue  = i_ctl.row ? 8'h00 : r_blue_err;

    assign q_red   = quant(i_red,   d_red);
    assign q_green = quant(i_green, d_green);
    assign q_blue  = quant(i_blue,  d_blue);

    assign o_index = 7'(q_red[10:8]) * 7'd25 + 7'(q_green[10:8]) * 7'd5
                   + 7'(q_blue[10:8]);

    always_comb begin
        n_red_err   = r_red_err;
        n_green_err = r_green_err;
        n_blue_err  = r_blue_err;
        if (i_ctl.fire) begin
            if (i_ctl.active) begin
                n_red_err   = q_red[7:0];
                n_green_err = q_green[7:0];
                n_blue_err  = q_blue[7:0];
            end else begin
                n_red_err   = d_red;
                n_green_err = d_green;
                n_blue_err  = d_blue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_err   <= '0;
            r_green_err <= '0;
            r_blue_err  <= '0;
        end else begin
            r_red_err   <= n_red_err;
            r_green_err <= n_green_err;
            r_blue_err  <= n_blue_err;
        end
    end

`ifndef ASSERT_OFF
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.fire |-> (o_index <= 7'd124))
        else $error("palette index out of range");

    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.fire && i_ctl.row && !i_ctl.active)
        |=> (r_red_err == 8'h00 && r_green_err == 8'h00 && r_blue_err == 8'h00))
        else $error("row start did not clear dither error");

    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.fire |=> $stable(r_red_err) && $stable(r_green_err) && $stable(r_blue_err))
        else $error("dither error moved without a request");
`endif

endmodule

@@ hdl/rgb_to_visual_pixel_packer_dither.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_visual_pixel_packer_dither
// RGB or gray pixel to packed display word, with an 8 bpp dithered palette.
// ----------------------------------------------------------------------------
// One pixel request per clock is taken and one word leaves per clock while
// the output does not stall; each pixel passes an input register and then a
// result register, which offers its word on the output. The one-per-clock
// rate holds because the dither error loop closes within the single stage
// between the two registers. A stalled output fills both registers, after
// which the input stalls too. Field mask top bits are found when a mask is
// written, so the pixel path only shifts, masks and swaps bytes. Write
// configuration only while no pixel is in flight.
module rgb_to_visual_pixel_packer_dither (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vpp_pix_if.sink          i_pix,
    vpp_word_if.source       o_word,
    vpp_cfg_if.sink          i_cfg
);

    vpp_pkg::t_cfg      r_cfg;
    vpp_pkg::t_dith_ctl dith_ctl;

    logic        r_a_valid;
    logic [7:0]  r_a_red, r_a_green, r_a_blue;
    logic        r_a_row;
    logic        r_b_valid;
    logic [31:0] r_b_word;

    logic        b_take;
    logic        a_adv;
    logic        pix_fire;
    logic [7:0]  s_green, s_blue;
    logic [31:0] pack_word;
    logic [6:0]  pal_index;
    logic [31:0] n_b_word;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_fld    <= vpp_pkg::RED_FLD_RST;
            r_cfg.green_fld  <= vpp_pkg::GREEN_FLD_RST;
            r_cfg.blue_fld   <= vpp_pkg::BLUE_FLD_RST;
            r_cfg.red_top    <= vpp_pkg::top_bit(vpp_pkg::RED_FLD_RST);
            r_cfg.green_top  <= vpp_pkg::top_bit(vpp_pkg::GREEN_FLD_RST);
            r_cfg.blue_top   <= vpp_pkg::top_bit(vpp_pkg::BLUE_FLD_RST);
            r_cfg.fmt        <= vpp_pkg::FMT_32;
            r_cfg.msb_first  <= 1'b0;
            r_cfg.gray       <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                vpp_pkg::CFG_RED_FLD: begin
                    r_cfg.red_fld <= i_cfg.data;
                    r_cfg.red_top <= vpp_pkg::top_bit(i_cfg.data);
                end
                vpp_pkg::CFG_GREEN_FLD: begin
                    r_cfg.green_fld <= i_cfg.data;
                    r_cfg.green_top <= vpp_pkg::top_bit(i_cfg.data);
                end
                vpp_pkg::CFG_BLUE_FLD: begin
                    r_cfg.blue_fld <= i_cfg.data;
                    r_cfg.blue_top <= vpp_pkg::top_bit(i_cfg.data);
                end
                vpp_pkg::CFG_FORMAT:    r_cfg.fmt       <= vpp_pkg::t_fmt'(i_cfg.data[1:0]);
                vpp_pkg::CFG_MSB_FIRST: r_cfg.msb_first <= i_cfg.data[0];
                vpp_pkg::CFG_GRAY:      r_cfg.gray      <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // two-register pipeline
    // ------------------------------------------------------------------
    assign b_take      = !r_b_valid || o_word.ready;
    assign a_adv       = r_a_valid && b_take;
    assign i_pix.ready = !r_a_valid || b_take;
    assign pix_fire    = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_a_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_fire) begin
            r_a_red   <= i_pix.red_in;
            r_a_green <= i_pix.green_in;
            r_a_blue  <= i_pix.blue_in;
            r_a_row   <= i_pix.row_begin;
        end
    end

    // gray sample feeds all channels
    assign s_green = r_cfg.gray ? r_a_red : r_a_green;
    assign s_blue  = r_cfg.gray ? r_a_red : r_a_blue;

    vpp_pack u_pack (
        .i_cfg   (r_cfg),
        .i_red   (r_a_red),
        .i_green (s_green),
        .i_blue  (s_blue),
        .o_word  (pack_word)
    );

    assign dith_ctl.fire   = a_adv;
    assign dith_ctl.row    = r_a_row;
    assign dith_ctl.active = (r_cfg.fmt == vpp_pkg::FMT_8);

    vpp_dither u_dither (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dith_ctl),
        .i_red   (r_a_red),
        .i_green (s_green),
        .i_blue  (s_blue),
        .o_index (pal_index)
    );

    assign n_b_word = dith_ctl.active ? {25'd0, pal_index} : pack_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_take) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_word <= n_b_word;
        end
    end

    assign o_word.valid      = r_b_valid;
    assign o_word.pixel_word = r_b_word;

`ifndef ASSERT_OFF
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv |=> r_b_valid)
        else $error("advancing request lost before the result register");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_take) |=> (r_a_valid && $stable(r_a_red) && $stable(r_a_row)))
        else $error("input register dropped a stalled request");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_a_valid && r_b_valid))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ verif/packed_word_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_word_check
// Predicts each packed pixel word from the accepted pixel requests and the
// register writes seen on the config channel, then compares it with the word
// that leaves the packer. Dither error state is tracked here.
// ----------------------------------------------------------------------------
module packed_word_check (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vpp_pix_if    i_pix,
    vpp_word_if   i_word,
    vpp_cfg_if    i_cfg,
    output int    o_mismatches,
    output int    o_outstanding,
    output int    o_checked
);

    localparam int QUANT_MASK = 'h1c0;
    localparam int LEVEL_TOP  = 'h100;

    typedef struct packed {
        logic [7:0] err;
        logic [2:0] level;
    } t_quant;

    logic [31:0]   expected_words[$];
    logic [31:0]   red_fld;
    logic [31:0]   green_fld;
    logic [31:0]   blue_fld;
    vpp_pkg::t_fmt fmt;
    logic          msb_first;
    logic          gray;
    logic [7:0]    red_err;
    logic [7:0]    green_err;
    logic [7:0]    blue_err;
    int            mismatch_count;
    int            outstanding;
    int            checked;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = outstanding;
    assign o_checked     = checked;

    task automatic report_mismatch(input string what);
        $display("[%0t] packed word error: %s", $time, what);
        mismatch_count++;
    endtask

    // bit 7 of the sample lands on the top set bit of the mask
    function automatic logic [31:0] place_field(input logic [7:0] v, input logic [31:0] mask);
        int          hi;
        logic [31:0] wide;
        hi = -1;
        for (int i = 0; i < 32; i++) begin
            if (mask[i]) begin
                hi = i;
            end
        end
        wide = {24'd0, v};
        if (hi < 0) begin
            return '0;
        end
        if (hi >= 7) begin
            return (wide << (hi - 7)) & mask;
        end
        return (wide >> (7 - hi)) & mask;
    endfunction

    // five-level quantiser with a wrapping 8-bit error carried along the row
    function automatic t_quant dither_step(input logic [7:0] t, input logic [7:0] err);
        int     d;
        int     ti;
        int     s;
        int     q;
        t_quant res;
        d  = $signed(err);
        ti = t;
        s  = ti + d;
        if (s > 0 && s < 256) begin
            if (d > -32 && d < 32) begin
                q = (s + 31) & QUANT_MASK;
            end else if (d > 31) begin
                q = (ti + 63) & QUANT_MASK;
            end else begin
                q = ti & QUANT_MASK;
            end
        end else if (s > 255) begin
            q = LEVEL_TOP;
        end else begin
            q = 0;
        end
        res.err   = 8'(d + ti - q);
        res.level = 3'(q >> 6);
        return res;
    endfunction

    function automatic logic [31:0] predict_word(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic row);
        logic [7:0]  gs;
        logic [7:0]  bs;
        logic [31:0] u;
        logic [31:0] w;
        t_quant      rq;
        t_quant      gq;
        t_quant      bq;
        if (row) begin
            red_err   = '0;
            green_err = '0;
            blue_err  = '0;
        end
        gs = gray ? r : g;
        bs = gray ? r : b;
        if (fmt == vpp_pkg::FMT_8) begin
            rq        = dither_step(r, red_err);
            gq        = dither_step(gs, green_err);
            bq        = dither_step(bs, blue_err);
            red_err   = rq.err;
            green_err = gq.err;
            blue_err  = bq.err;
            w = 32'(rq.level) * 25 + 32'(gq.level) * 5 + 32'(bq.level);
        end else if (gray) begin
            unique case (fmt)
                vpp_pkg::FMT_32: w = msb_first ? {r, r, r, 8'h00} : {8'h00, r, r, r};
                vpp_pkg::FMT_24: w = {8'h00, r, r, r};
                default:         w = {16'h0000, r[7:3], r[7:2], r[7:3]};
            endcase
        end else begin
            u = place_field(r, red_fld) | place_field(gs, green_fld)
              | place_field(bs, blue_fld);
            unique case (fmt)
                vpp_pkg::FMT_32: w = msb_first ? {u[7:0], u[15:8], u[23:16], u[31:24]} : u;
                vpp_pkg::FMT_24: w = msb_first ? {8'h00, u[7:0], u[15:8], u[23:16]}
                                               : {8'h00, u[23:0]};
                default: w = msb_first ? {16'h0000, u[7:0], u[15:8]} : {16'h0000, u[15:0]};
            endcase
        end
        return w;
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            expected_words.delete();
            red_fld        = vpp_pkg::RED_FLD_RST;
            green_fld      = vpp_pkg::GREEN_FLD_RST;
            blue_fld       = vpp_pkg::BLUE_FLD_RST;
            fmt            = vpp_pkg::FMT_32;
            msb_first      = 1'b0;
            gray           = 1'b0;
            red_err        = '0;
            green_err      = '0;
            blue_err       = '0;
            mismatch_count = 0;
            checked        = 0;
        end else begin
            if (i_word.valid && i_word.ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("word %08h with no request outstanding",
                                              i_word.pixel_word));
                end else begin
                    want = expected_words.pop_front();
                    checked++;
                    if (i_word.pixel_word !== want) begin
                        report_mismatch($sformatf("word %0d: pixel_word %08h, predicted %08h",
                                                  checked, i_word.pixel_word, want));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (vpp_pkg::t_cfg_idx'(i_cfg.index))
                    vpp_pkg::CFG_RED_FLD:   red_fld   = i_cfg.data;
                    vpp_pkg::CFG_GREEN_FLD: green_fld = i_cfg.data;
                    vpp_pkg::CFG_BLUE_FLD:  blue_fld  = i_cfg.data;
                    vpp_pkg::CFG_FORMAT:    fmt       = vpp_pkg::t_fmt'(i_cfg.data[1:0]);
                    vpp_pkg::CFG_MSB_FIRST: msb_first = i_cfg.data[0];
                    vpp_pkg::CFG_GRAY:      gray      = i_cfg.data[0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_words.push_back(predict_word(i_pix.red_in, i_pix.green_in,
                                                      i_pix.blue_in, i_pix.row_begin));
            end
        end
        outstanding = expected_words.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Pixel packer bench: a directed pass over every format, byte order and gray
// case, then random register settings with rows of random pixels under
// varying source gaps and sink stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HOLD_CYCLES  = 60;
    localparam int PHASES       = 14;
    localparam int PHASE_PIXELS = 54;
    localparam int DRAIN_LIMIT  = 5000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int pixels_sent   = 0;
    int settings_used = 0;
    int mismatches;
    int outstanding;
    int checked;

    vpp_pix_if  pix_ch ();
    vpp_word_if word_ch ();
    vpp_cfg_if  cfg_ch ();

    always #4 i_clk = ~i_clk;

    rgb_to_visual_pixel_packer_dither dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_word  (word_ch),
        .i_cfg   (cfg_ch)
    );

    packed_word_check word_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pix         (pix_ch),
        .i_word        (word_ch),
        .i_cfg         (cfg_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        #3_000_000;
        $display("rgb_to_visual_pixel_packer_dither: mismatch");
        $finish;
    end

    // output side: random stalls, or a counted hold-off when one is asked for
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left     = 0;
        hold_taken    = 1'b0;
        word_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0 && !hold_taken) begin
                hold_left  = hold_req;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                word_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                word_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
        endcase
    endtask

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic row);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.red_in    <= r;
        pix_ch.green_in  <= g;
        pix_ch.blue_in   <= b;
        pix_ch.row_begin <= row;
        @(posedge i_clk);
        while (!pix_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // every request yields one word, so an empty prediction queue means idle
    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic set_reg(input vpp_pkg::t_cfg_idx idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] rm, input logic [31:0] gm,
                                 input logic [31:0] bm, input vpp_pkg::t_fmt f,
                                 input logic msb, input logic gray);
        wait_idle();
        set_reg(vpp_pkg::CFG_RED_FLD, rm);
        set_reg(vpp_pkg::CFG_GREEN_FLD, gm);
        set_reg(vpp_pkg::CFG_BLUE_FLD, bm);
        set_reg(vpp_pkg::CFG_FORMAT, 32'(f));
        set_reg(vpp_pkg::CFG_MSB_FIRST, 32'(msb));
        set_reg(vpp_pkg::CFG_GRAY, 32'(gray));
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] rand_sample();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'($urandom_range(31));
            3:       return 8'($urandom_range(255, 224));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] rand_mask();
        int unsigned w;
        int unsigned lo;
        case ($urandom_range(6))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h0000_0001;
            4: return $urandom();
            default: begin
                w  = $urandom_range(32, 1);
                lo = $urandom_range(32 - w);
                return 32'(((64'd1 << w) - 64'd1) << lo);
            end
        endcase
    endfunction

    initial begin
        int   n;
        int   row_len;
        int   guard;
        logic row;

        pix_ch.valid     = 1'b0;
        pix_ch.red_in    = '0;
        pix_ch.green_in  = '0;
        pix_ch.blue_in   = '0;
        pix_ch.row_begin = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings first, then each format and special case
        set_idling(0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'h80, 8'h01, 8'hfe, 1'b0);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_32, 1'b1, 1'b0);
        send_pixel(8'h12, 8'h34, 8'h56, 1'b1);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_24, 1'b1, 1'b0);
        send_pixel(8'hab, 8'hcd, 8'hef, 1'b0);
        apply_setting(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, vpp_pkg::FMT_16,
                      1'b1, 1'b0);
        send_pixel(8'hff, 8'h00, 8'h80, 1'b1);
        send_pixel(8'h01, 8'hff, 8'h7f, 1'b0);
        // empty red field, green above the pixel, blue squeezed into bit 0
        apply_setting(32'h0000_0000, 32'hff00_0000, 32'h0000_0001, vpp_pkg::FMT_16,
                      1'b0, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
        apply_setting(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, vpp_pkg::FMT_32,
                      1'b0, 1'b0);
        send_pixel(8'ha5, 8'h5a, 8'h3c, 1'b0);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_32, 1'b0, 1'b1);
        send_pixel(8'hc3, 8'h11, 8'h22, 1'b0);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_32, 1'b1, 1'b1);
        send_pixel(8'hc3, 8'h11, 8'h22, 1'b0);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_24, 1'b1, 1'b1);
        send_pixel(8'h5e, 8'hff, 8'h00, 1'b0);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_16, 1'b1, 1'b1);
        send_pixel(8'hff, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h7b, 8'h00, 8'h00, 1'b0);
        // dither: saturating run builds up error, then a fresh row clears it
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_8, 1'b0, 1'b0);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
        send_pixel(8'hff, 8'hff, 8'hff, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h7f, 8'h80, 8'h40, 1'b0);
        send_pixel(8'h10, 8'hf0, 8'hc8, 1'b0);
        send_pixel(8'hff, 8'h00, 8'hff, 1'b1);
        apply_setting(vpp_pkg::RED_FLD_RST, vpp_pkg::GREEN_FLD_RST, vpp_pkg::BLUE_FLD_RST,
                      vpp_pkg::FMT_8, 1'b1, 1'b1);
        send_pixel(8'h90, 8'h00, 8'hff, 1'b1);
        send_pixel(8'h90, 8'hff, 8'h00, 1'b0);

        // random: rows of random length, now and then a row without its start
        for (int phase = 0; phase < PHASES; phase++) begin
            apply_setting(rand_mask(), rand_mask(), rand_mask(),
                          (phase < 8) ? vpp_pkg::t_fmt'(phase % 4)
                                      : vpp_pkg::t_fmt'($urandom_range(3)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
            set_idling(phase);
            if (phase == 4) begin
                hold_req = HOLD_CYCLES;
            end
            n = 0;
            while (n < PHASE_PIXELS) begin
                row_len = $urandom_range(16, 1);
                for (int k = 0; k < row_len && n < PHASE_PIXELS; k++) begin
                    row = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                    send_pixel(rand_sample(), rand_sample(), rand_sample(), row);
                    n++;
                end
            end
        end

        pix_ch.valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (4) @(negedge i_clk);

        $display("covered %0d pixels under %0d register settings: all formats, gray and colour,",
                 pixels_sent, settings_used);
        $display("both byte orders, dithered rows; %0d words compared, %0d-cycle sink hold-off",
                 checked, HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("rgb_to_visual_pixel_packer_dither: match");
        end else begin
            $display("rgb_to_visual_pixel_packer_dither: mismatch");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/vpp_pkg.sv
hdl/vpp_if.sv
hdl/vpp_pack.sv
hdl/vpp_dither.sv
hdl/rgb_to_visual_pixel_packer_dither.sv
verif/packed_word_check.sv
verif/tb_top.sv
